>>> design/keyed_sum_hash_table_macros.svh
// assertion macros used by the port-level checker file
// no dependencies
`ifndef KEYED_SUM_HASH_TABLE_MACROS_SVH
`define KEYED_SUM_HASH_TABLE_MACROS_SVH
// implication assertion, disabled while rst_n is low
`define KSH_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication assertion
`define KSH_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> design/ksht_pkg.sv
// types and constants for the keyed sum hash table
// no dependencies
`default_nettype none
package ksht_pkg;
  localparam logic [63:0] HASH_MULT = 64'd11400714819323198485;
  localparam logic [62:0] SUM_MAX = {63{1'b1}};
  localparam int unsigned LOAD_NUM = 3;
  localparam int unsigned LOAD_DEN = 2;

  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_POP = 1'b1;

  localparam logic [2:0] ST_UPDATED = 3'd0;
  localparam logic [2:0] ST_NEW     = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_POPPED  = 3'd3;
  localparam logic [2:0] ST_MISSED  = 3'd4;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HASH, S_RD, S_CMP, S_ADD, S_SH_RD, S_SH_HASH, S_SH_CMP,
    S_SH_WR, S_DONE
  } state_t;
endpackage
`default_nettype wire

>>> design/ksht_hash.sv
// iterative hash unit: key times the fibonacci constant, low bits only
// uses ksht_pkg; 8 bits of multiplier per cycle, lowest byte first
`default_nettype none
module ksht_hash import ksht_pkg::*; #(
  parameter int unsigned IDX_W = 6
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             go,
  input  wire logic [63:0]      key,
  output logic                  done,
  output logic [IDX_W-1:0]      home
);
  logic [63:0] acc_r, acc_nxt;
  logic [63:0] key_r, key_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic        run_r, run_nxt;
  logic [7:0]  digit;
  logic [71:0] prod;

  // only the low IDX_W bits matter, so shifted partial products may truncate
  always_comb begin
    digit = HASH_MULT[cnt_r[2:0]*8 +: 8];
    prod  = {8'd0, key_r} * {64'd0, digit};
    acc_nxt = acc_r;
    key_nxt = key_r;
    cnt_nxt = cnt_r;
    run_nxt = run_r;
    if (go) begin
      acc_nxt = 64'd0;
      key_nxt = key;
      cnt_nxt = 4'd0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      acc_nxt = acc_r + prod[63:0];
      key_nxt = {key_r[55:0], 8'd0};
      cnt_nxt = cnt_r + 4'd1;
      if (cnt_r == 4'd7) run_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= 4'd0;
    end else begin
      run_r <= run_nxt;
      cnt_r <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    key_r <= key_nxt;
  end

  assign done = !run_r && !go;
  assign home = acc_r[IDX_W-1:0];
endmodule
`default_nettype wire

>>> design/keyed_sum_hash_table.sv
// Open-addressing hash table keeping a saturating 63-bit sum per 64-bit key, linear probing,
// pop with backward-shift deletion. After reset a clearing pass writes every slot empty with
// busy high. A command is taken when start is high and busy low. Busy then stays high while
// the command hashes its key and probes slots, and for a pop that hits also while it walks
// the occupied followers in the shift loop, where the shared hash unit rehashes each follower.
// The one result beat per command is strobed by out_valid in the first cycle that busy is
// low again. The receiver cannot stall: it must take every beat in the cycle it appears.
// uses ksht_pkg, ksht_hash
`default_nettype none
module keyed_sum_hash_table import ksht_pkg::*; #(
  parameter int unsigned TABLE_SLOTS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_command,
  input  wire logic [63:0] in_key,
  input  wire logic [62:0] in_add_amount,
  output logic             out_valid,
  output logic [2:0]       out_status,
  output logic [62:0]      out_popped_sum
);
  localparam int unsigned IDX_W = $clog2(TABLE_SLOTS);
  localparam int unsigned CNT_W = IDX_W + 1;
  localparam logic [CNT_W+1:0] LIMIT = (CNT_W+2)'(TABLE_SLOTS * LOAD_DEN);

  logic [127:0] mem [TABLE_SLOTS];   // {valid(1), key(64), sum(63)}
  logic [127:0] rd_r;
  logic [IDX_W-1:0] rd_addr;
  logic         we;
  logic [IDX_W-1:0] wa;
  logic [127:0] wd;

  state_t state_r, state_nxt;
  logic [IDX_W-1:0] s_r, s_nxt, hole_r, hole_nxt;
  logic [CNT_W-1:0] n_r, n_nxt, used_r, used_nxt;
  logic         cmd_r;
  logic [63:0]  key_r;
  logic [62:0]  amt_r;
  logic         hit_r, hit_nxt;
  logic [127:0] ent_r, ent_nxt;
  logic [2:0]   st_r, st_nxt;
  logic [62:0]  ps_r, ps_nxt;
  logic         ov_r, ov_nxt;
  logic         hgo;
  logic [63:0]  hkey;
  logic         hdone;
  logic [IDX_W-1:0] hhome;
  logic [63:0]  sum_add;
  logic [IDX_W-1:0] d_home, d_hole;
  logic         sh_go_r;
  logic         hgo_all;
  logic [63:0]  hkey_all;

  ksht_hash #(.IDX_W(IDX_W)) u_hash (
    .clk(clk), .rst_n(rst_n), .go(hgo_all), .key(hkey_all), .done(hdone), .home(hhome)
  );

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_r <= mem[rd_addr];
  end

  assign sum_add = {1'b0, ent_r[62:0]} + {1'b0, amt_r};
  assign d_home = s_r - hhome;
  assign d_hole = s_r - hole_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR:   if (n_r == CNT_W'(TABLE_SLOTS - 1)) state_nxt = S_IDLE;
      S_IDLE:    if (start) state_nxt = S_HASH;
      S_HASH:    if (hdone) state_nxt = S_RD;
      S_RD:      state_nxt = S_CMP;
      S_CMP: begin
        if (!rd_r[127] || rd_r[126:63] == key_r || n_r == CNT_W'(TABLE_SLOTS - 1)) begin
          if (cmd_r == CMD_ADD) state_nxt = S_ADD;
          else if (rd_r[127] && rd_r[126:63] == key_r) state_nxt = S_SH_RD;
          else state_nxt = S_DONE;
        end else state_nxt = S_RD;
      end
      S_ADD:     state_nxt = S_DONE;
      S_SH_RD:   state_nxt = S_SH_HASH;
      S_SH_HASH: state_nxt = !rd_r[127] || n_r == CNT_W'(TABLE_SLOTS) ? S_SH_WR :
                             (hdone ? S_SH_CMP : S_SH_HASH);
      S_SH_CMP:  state_nxt = S_SH_RD;
      S_SH_WR:   state_nxt = S_DONE;
      S_DONE:    state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    s_nxt = s_r; hole_nxt = hole_r; n_nxt = n_r; used_nxt = used_r;
    hit_nxt = hit_r; ent_nxt = ent_r; st_nxt = st_r; ps_nxt = ps_r; ov_nxt = 1'b0;
    we = 1'b0; wa = s_r; wd = '0; rd_addr = s_r;
    hgo = 1'b0; hkey = key_r;
    case (state_r)
      S_CLEAR: begin
        we = 1'b1; wa = n_r[IDX_W-1:0];
        n_nxt = n_r + 1'b1;
      end
      S_IDLE: begin
        hgo = start; hkey = in_key; n_nxt = '0;
      end
      S_HASH: if (hdone) s_nxt = hhome;
      S_RD: ;
      S_CMP: begin
        ent_nxt = rd_r;
        hit_nxt = rd_r[127] && rd_r[126:63] == key_r;
        if (!(!rd_r[127] || hit_nxt || n_r == CNT_W'(TABLE_SLOTS - 1))) begin
          s_nxt = s_r + 1'b1; n_nxt = n_r + 1'b1;
          rd_addr = s_r + 1'b1;
        end else if (cmd_r == CMD_POP) begin
          if (hit_nxt) begin
            st_nxt = ST_POPPED; ps_nxt = rd_r[62:0];
            hole_nxt = s_r; s_nxt = s_r + 1'b1; n_nxt = '0;
          end else begin
            st_nxt = ST_MISSED; ps_nxt = '0;
          end
        end
      end
      S_ADD: begin
        ps_nxt = '0;
        if (hit_r) begin
          st_nxt = ST_UPDATED;
          we = 1'b1;
          wd = {1'b1, key_r, sum_add[63] ? SUM_MAX : sum_add[62:0]};
        end else if ({2'b00, used_r} * (CNT_W+2)'(LOAD_NUM) >= LIMIT || ent_r[127]) begin
          st_nxt = ST_FULL;
        end else begin
          st_nxt = ST_NEW; used_nxt = used_r + 1'b1;
          we = 1'b1;
          wd = {1'b1, key_r, amt_r};
        end
      end
      S_SH_RD: begin
        rd_addr = s_r;
      end
      S_SH_HASH: ;
      S_SH_CMP: begin
        // move the follower back only if its home does not lie after the hole
        if (d_home >= d_hole) begin
          we = 1'b1; wa = hole_r; wd = rd_r; hole_nxt = s_r;
        end
        s_nxt = s_r + 1'b1; n_nxt = n_r + 1'b1;
        rd_addr = s_r + 1'b1;
      end
      S_SH_WR: begin
        we = 1'b1; wa = hole_r; wd = '0;
        if (used_r != '0) used_nxt = used_r - 1'b1;
      end
      S_DONE: ov_nxt = 1'b1;
      default: ;
    endcase
  end

  // follower hash is launched the cycle its word arrives
  always_ff @(posedge clk) begin
    if (!rst_n) sh_go_r <= 1'b0;
    else sh_go_r <= (state_r == S_SH_RD);
  end

  assign hgo_all = hgo || sh_go_r;
  assign hkey_all = sh_go_r ? rd_r[126:63] : hkey;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR; n_r <= '0; used_r <= '0; ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt; n_r <= n_nxt; used_r <= used_nxt; ov_r <= ov_nxt;
    end
    s_r <= s_nxt; hole_r <= hole_nxt; hit_r <= hit_nxt; ent_r <= ent_nxt;
    st_r <= st_nxt; ps_r <= ps_nxt;
    if (state_r == S_IDLE && start) begin
      cmd_r <= in_command; key_r <= in_key; amt_r <= in_add_amount;
    end
  end

  assign busy = state_r != S_IDLE;
  assign out_valid = ov_r;
  assign out_status = st_r;
  assign out_popped_sum = ps_r;
endmodule
`default_nettype wire

>>> design/keyed_sum_hash_table_checker.sv
// port-level checker for keyed_sum_hash_table, bound to the top level
// uses keyed_sum_hash_table_macros.svh and ksht_pkg
`default_nettype none
`include "keyed_sum_hash_table_macros.svh"
module keyed_sum_hash_table_checker import ksht_pkg::*; (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        out_valid,
  input wire logic [2:0]  out_status,
  input wire logic [62:0] out_popped_sum
);
  `KSH_ASSERT_IMP(a_status_range, clk, rst_n, out_valid, out_status <= ST_MISSED)
  `KSH_ASSERT_IMP(a_sum_zero, clk, rst_n, out_valid && out_status != ST_POPPED,
    out_popped_sum == '0)
  `KSH_ASSERT_NXT(a_busy_after_start, clk, rst_n, start && !busy, busy)
  `KSH_ASSERT_NXT(a_single_beat, clk, rst_n, out_valid, !out_valid)
endmodule

bind keyed_sum_hash_table keyed_sum_hash_table_checker u_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid),
  .out_status(out_status), .out_popped_sum(out_popped_sum)
);
`default_nettype wire

>>> tb/sv/ksht_checker.sv
// checker for the keyed sum hash table: watches command and result beats,
// predicts each result from its own copy of the table and compares
// depends on ksht_pkg
`timescale 1ns / 100ps
module ksht_checker import ksht_pkg::*; #(
  parameter int unsigned TABLE_SLOTS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic        in_command,
  input  wire logic [63:0] in_key,
  input  wire logic [62:0] in_add_amount,
  input  wire logic        out_valid,
  input  wire logic [2:0]  out_status,
  input  wire logic [62:0] out_popped_sum,
  output int               error_count,
  output int               pending_count
);
  localparam int unsigned MASK = TABLE_SLOTS - 1;

  typedef struct packed {
    logic [2:0]  status;
    logic [62:0] popped_sum;
  } outcome_t;

  logic        tbl_valid [TABLE_SLOTS];
  logic [63:0] tbl_key   [TABLE_SLOTS];
  logic [62:0] tbl_sum   [TABLE_SLOTS];
  int unsigned tbl_used;
  outcome_t    outcomes_due[$];

  function automatic int unsigned home_slot(logic [63:0] key);
    logic [63:0] prod;
    prod = key * HASH_MULT;
    return prod[31:0] & MASK;
  endfunction

  task automatic report(string what, logic [65:0] got, logic [65:0] want);
    $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
    error_count++;
  endtask

  // walk the chain to the key or the first hole
  task automatic find_slot(input logic [63:0] key, output int unsigned s, output bit hit);
    s = home_slot(key);
    hit = 0;
    for (int n = 0; n < TABLE_SLOTS; n++) begin
      if (!tbl_valid[s]) return;
      if (tbl_key[s] == key) begin
        hit = 1;
        return;
      end
      s = (s + 1) & MASK;
    end
  endtask

  task automatic backshift_remove(int unsigned slot);
    int unsigned hole, nxt, hm;
    hole = slot;
    nxt = (hole + 1) & MASK;
    for (int n = 0; n < TABLE_SLOTS && tbl_valid[nxt]; n++) begin
      hm = home_slot(tbl_key[nxt]);
      if (((nxt - hm) & MASK) >= ((nxt - hole) & MASK)) begin
        tbl_key[hole] = tbl_key[nxt];
        tbl_sum[hole] = tbl_sum[nxt];
        hole = nxt;
      end
      nxt = (nxt + 1) & MASK;
    end
    tbl_valid[hole] = 0;
    tbl_key[hole] = '0;
    tbl_sum[hole] = '0;
    if (tbl_used > 0) tbl_used--;
  endtask

  task automatic predict_outcome(logic cmd, logic [63:0] key, logic [62:0] amt);
    int unsigned s;
    bit hit;
    outcome_t o;
    logic [63:0] total;
    o = '0;
    find_slot(key, s, hit);
    if (cmd == CMD_ADD) begin
      if (!hit && (tbl_used * LOAD_NUM >= TABLE_SLOTS * LOAD_DEN || tbl_valid[s])) begin
        o.status = ST_FULL;
      end else begin
        if (!hit) begin
          tbl_valid[s] = 1;
          tbl_key[s] = key;
          tbl_sum[s] = '0;
          tbl_used++;
          o.status = ST_NEW;
        end else begin
          o.status = ST_UPDATED;
        end
        total = {1'b0, tbl_sum[s]} + {1'b0, amt};
        tbl_sum[s] = total[63] ? SUM_MAX : total[62:0];
      end
    end else if (!hit) begin
      o.status = ST_MISSED;
    end else begin
      o.status = ST_POPPED;
      o.popped_sum = tbl_sum[s];
      backshift_remove(s);
    end
    outcomes_due.push_back(o);
  endtask

  always @(posedge clk) begin
    outcome_t want;
    if (!rst_n) begin
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        tbl_valid[i] = 0;
        tbl_key[i] = '0;
        tbl_sum[i] = '0;
      end
      tbl_used = 0;
      outcomes_due.delete();
      error_count = 0;
    end else begin
      if (out_valid) begin
        if (outcomes_due.size() == 0) begin
          report("unexpected beat status", out_status, 0);
        end else begin
          want = outcomes_due.pop_front();
          if (out_status !== want.status) report("status", out_status, want.status);
          if (out_popped_sum !== want.popped_sum)
            report("popped_sum", out_popped_sum, want.popped_sum);
        end
      end
      if (start && !busy) predict_outcome(in_command, in_key, in_add_amount);
    end
    pending_count = outcomes_due.size();
  end
endmodule

>>> tb/sv/tb_keyed_sum_hash_table.sv
// top of the keyed sum hash table testbench: clock, reset, command stimulus
// and verdict; depends on ksht_pkg, ksht_checker and the block
`timescale 1ns / 100ps
module tb_keyed_sum_hash_table;
  import ksht_pkg::*;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        start = 0;
  logic        in_command = CMD_ADD;
  logic [63:0] in_key = '0;
  logic [62:0] in_add_amount = '0;
  wire         busy, out_valid;
  wire [2:0]   out_status;
  wire [62:0]  out_popped_sum;
  int          error_count, pending_count;
  logic [63:0] key_pool[24];

  always #6 clk = ~clk;

  keyed_sum_hash_table #(.TABLE_SLOTS(64)) dut (.*);
  ksht_checker #(.TABLE_SLOTS(64)) chk (.*);

  // hold start until the block takes the beat
  task automatic issue(logic cmd, logic [63:0] key, logic [62:0] amt);
    start <= 1;
    in_command <= cmd;
    in_key <= key;
    in_add_amount <= amt;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic pause_sender();
    start <= 0;
    in_key <= {$urandom, $urandom};
    in_add_amount <= 63'({$urandom, $urandom});
    repeat ($urandom_range(1, 30)) @(negedge clk);
  endtask

  function automatic logic [62:0] rand_amount();
    case ($urandom_range(0, 3))
      0: return SUM_MAX - 63'($urandom_range(0, 3));
      1: return 63'({$urandom, $urandom});
      default: return 63'($urandom_range(0, 1000));
    endcase
  endfunction

  initial begin
    #60_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int sent, burst;
    logic [63:0] k;
    foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
    repeat (12) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    // directed: zero key, all-ones key, zero amount, saturation, misses
    issue(CMD_POP, 64'd5, '0);
    issue(CMD_ADD, 64'd0, '0);
    issue(CMD_ADD, 64'd0, SUM_MAX);
    issue(CMD_ADD, 64'd0, 63'd1);
    issue(CMD_POP, 64'd0, SUM_MAX);
    issue(CMD_POP, 64'd0, '0);
    issue(CMD_ADD, '1, SUM_MAX);
    issue(CMD_ADD, '1, SUM_MAX);
    issue(CMD_POP, '1, '0);
    // fill to the load limit so adds are refused, then drain in another order
    for (int i = 0; i < 50; i++) issue(CMD_ADD, 64'd64 * i + 7, 63'(i));
    issue(CMD_ADD, 64'd3, '0);
    for (int i = 0; i < 50; i += 2) issue(CMD_POP, 64'd64 * i + 7, '0);
    for (int i = 49; i > 0; i -= 2) issue(CMD_POP, 64'd64 * i + 7, '0);
    sent = 0;
    while (sent < 1000) begin
      burst = $urandom_range(1, 20);
      for (int b = 0; b < burst; b++) begin
        case ($urandom_range(0, 9))
          0: k = {$urandom, $urandom};
          1: k = 64'd64 * $urandom_range(0, 40) + 1;
          default: k = key_pool[$urandom_range(0, 23)];
        endcase
        issue($urandom_range(0, 9) < 4 ? CMD_POP : CMD_ADD, k, rand_amount());
        sent++;
      end
      if ($urandom_range(0, 3) != 0) pause_sender();
    end
    start <= 0;
    while (pending_count != 0) @(negedge clk);
    repeat (2000) @(negedge clk);
    if (error_count == 0 && pending_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

>>> files.f
+incdir+design
design/ksht_pkg.sv
design/ksht_hash.sv
design/keyed_sum_hash_table.sv
design/keyed_sum_hash_table_checker.sv
tb/sv/ksht_checker.sv
tb/sv/tb_keyed_sum_hash_table.sv
